// ----- rtl/htd_pkg.sv -----
// ----------------------------------------------------------------------------
// htd_pkg
// Shared constants, codes and types of the huffman tree build and decode block.
// ----------------------------------------------------------------------------
package htd_pkg;

  // tree sizing
  localparam int MaxSymbols = 256;
  localparam int NodeLimit  = 2 * MaxSymbols - 1;
  localparam int NodeDepth  = NodeLimit;
  localparam int NodeW      = $clog2(NodeDepth);
  localparam int ListW      = $clog2(MaxSymbols);
  localparam int LoadW      = $clog2(MaxSymbols + 1);
  localparam int ByteBits   = 8;
  localparam int BitW       = $clog2(ByteBits + 1);
  localparam int SymW       = 8;
  localparam int LenW       = 24;
  localparam int OpW        = 2;

  // operation codes
  localparam logic [OpW-1:0] OpLoad   = 2'd0;
  localparam logic [OpW-1:0] OpTopo   = 2'd1;
  localparam logic [OpW-1:0] OpDecode = 2'd2;
  localparam logic [OpW-1:0] OpClear  = 2'd3;

  // classified command from the front end
  typedef struct packed {
    logic            is_load;
    logic            is_topo;
    logic            is_decode;
    logic            is_clear;
    logic [SymW-1:0] data;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            error;
    logic            done;
  } res_t;

endpackage

// ----- rtl/htd_front.sv -----
// ----------------------------------------------------------------------------
// htd_front
// Input side: decodes the operation of each transaction and keeps the
// commands in a two entry queue toward the execution engine.
// ----------------------------------------------------------------------------
module htd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [htd_pkg::OpW-1:0]  operation,
  input  logic [htd_pkg::SymW-1:0] data_byte,
  output logic                     full,
  output logic                     cmd_valid,
  output htd_pkg::cmd_t            cmd,
  input  logic                     cmd_take
);
  import htd_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       incoming;
  logic       do_push;
  logic       do_take;

  // operation decoder
  always_comb begin
    incoming = '0;
    incoming.data = data_byte;
    unique case (operation)
      OpLoad:   incoming.is_load   = 1'b1;
      OpTopo:   incoming.is_topo   = 1'b1;
      OpDecode: incoming.is_decode = 1'b1;
      OpClear:  incoming.is_clear  = 1'b1;
      default:  incoming.is_clear  = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entry[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_take) rd_ptr <= !rd_ptr;
      if (do_push && !do_take) begin
        count <= count + 2'd1;
      end else if (do_take && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= incoming;
  end

endmodule

// ----- rtl/htd_out_queue.sv -----
// ----------------------------------------------------------------------------
// htd_out_queue
// Four entry result queue between the execution engine and the result ports.
// ----------------------------------------------------------------------------
module htd_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  htd_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output htd_pkg::res_t dout
);
  import htd_pkg::*;

  res_t       entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign dout    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      if (do_push && !do_pop) begin
        count <= count + 3'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 3'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= din;
  end

endmodule

// ----- rtl/htd_back.sv -----
// ----------------------------------------------------------------------------
// htd_back
// Execution engine: symbol list loads, tree build from topology bits and the
// bit serial tree walk, one node memory read per coded bit.
// ----------------------------------------------------------------------------
module htd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [htd_pkg::LenW-1:0] output_length,
  input  logic                     cmd_valid,
  input  htd_pkg::cmd_t            cmd,
  output logic                     cmd_take,
  output logic                     res_push,
  output htd_pkg::res_t            res_data,
  input  logic                     res_full
);
  import htd_pkg::*;

  // engine states
  localparam logic [2:0] StIdle       = 3'd0;
  localparam logic [2:0] StBuildBit   = 3'd1;
  localparam logic [2:0] StBuildClimb = 3'd2;
  localparam logic [2:0] StBuildLink  = 3'd3;
  localparam logic [2:0] StDecode     = 3'd4;

  // node and symbol memories
  logic [NodeW-1:0] left_mem   [NodeDepth];
  logic [NodeW-1:0] right_mem  [NodeDepth];
  logic [NodeW-1:0] parent_mem [NodeDepth];
  logic [SymW-1:0]  sym_mem    [NodeDepth];
  logic [SymW-1:0]  slist_mem  [MaxSymbols];

  logic [NodeW-1:0] left_q, right_q, parent_q;
  logic [SymW-1:0]  sym_q, slist_q;

  // memory controls
  logic             left_we, right_we, parent_we, sym_we, slist_we;
  logic [NodeW-1:0] left_waddr, right_waddr, parent_waddr, sym_waddr;
  logic [NodeW-1:0] left_wdata, right_wdata, parent_wdata;
  logic [SymW-1:0]  sym_wdata;
  logic [ListW-1:0] slist_waddr;
  logic             node_re, build_re;
  logic [NodeW-1:0] node_raddr;

  // registers
  logic [2:0]       state, state_next;
  logic [SymW-1:0]  shift, shift_next;
  logic [BitW-1:0]  bits_left, bits_left_next;
  logic [LoadW-1:0] symbols_loaded, symbols_loaded_next;
  logic [LoadW-1:0] symbols_used, symbols_used_next;
  logic [NodeW-1:0] nodes_used, nodes_used_next;
  logic [NodeW-1:0] build_node, build_node_next;
  logic             previous_bit, previous_bit_next;
  logic             build_finished, build_finished_next;
  logic [NodeW-1:0] walk_node, walk_node_next;
  logic [LenW-1:0]  symbols_emitted, symbols_emitted_next;
  logic             halted, halted_next;
  logic [NodeW-1:0] root_left, root_left_next;
  logic [NodeW-1:0] root_right, root_right_next;
  logic             chk, chk_next;
  logic             hold_valid, hold_valid_next;
  res_t             hold, hold_next;
  logic [NodeW-1:0] link_node, link_node_next;
  logic [NodeW-1:0] link_child, link_child_next;
  logic             link_right, link_right_next;

  // helpers
  logic             bit_in;
  logic [NodeW-1:0] cur_left, cur_right, child;
  logic             q_leaf;
  logic             can_push;
  logic [LenW-1:0]  emitted_inc;
  logic             ev_result, ev_flush;
  res_t             new_res;

  assign bit_in      = shift[ByteBits-1];
  assign cur_left    = (walk_node == '0) ? root_left : left_q;
  assign cur_right   = (walk_node == '0) ? root_right : right_q;
  assign child       = bit_in ? cur_right : cur_left;
  assign q_leaf      = (left_q == '0) && (right_q == '0);
  assign can_push    = !res_full || !hold_valid;
  assign emitted_inc = symbols_emitted + LenW'(1);

  // engine next state
  always_comb begin
    state_next           = state;
    shift_next           = shift;
    bits_left_next       = bits_left;
    symbols_loaded_next  = symbols_loaded;
    symbols_used_next    = symbols_used;
    nodes_used_next      = nodes_used;
    build_node_next      = build_node;
    previous_bit_next    = previous_bit;
    build_finished_next  = build_finished;
    walk_node_next       = walk_node;
    symbols_emitted_next = symbols_emitted;
    halted_next          = halted;
    root_left_next       = root_left;
    root_right_next      = root_right;
    chk_next             = chk;
    hold_valid_next      = hold_valid;
    hold_next            = hold;
    link_node_next       = link_node;
    link_child_next      = link_child;
    link_right_next      = link_right;

    cmd_take     = 1'b0;
    res_push     = 1'b0;
    res_data     = hold;
    ev_result    = 1'b0;
    ev_flush     = 1'b0;
    new_res      = '0;

    left_we      = 1'b0;
    right_we     = 1'b0;
    parent_we    = 1'b0;
    sym_we       = 1'b0;
    slist_we     = 1'b0;
    left_waddr   = build_node;
    right_waddr  = build_node;
    parent_waddr = nodes_used;
    sym_waddr    = build_node;
    left_wdata   = '0;
    right_wdata  = '0;
    parent_wdata = build_node;
    sym_wdata    = '0;
    slist_waddr  = symbols_loaded[ListW-1:0];
    node_re      = 1'b0;
    build_re     = 1'b0;
    node_raddr   = walk_node;

    unique case (state)
      StIdle: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.is_load) begin
            // append to the symbol list while there is room
            if (symbols_loaded < LoadW'(MaxSymbols)) begin
              slist_we            = 1'b1;
              symbols_loaded_next = symbols_loaded + LoadW'(1);
            end
          end else if (cmd.is_topo) begin
            shift_next     = cmd.data;
            bits_left_next = BitW'(ByteBits);
            state_next     = StBuildBit;
          end else if (cmd.is_decode) begin
            // fetch the children of the node the walk stopped on
            shift_next     = cmd.data;
            bits_left_next = BitW'(ByteBits);
            chk_next       = 1'b0;
            node_re        = 1'b1;
            state_next     = StDecode;
          end else if (cmd.is_clear) begin
            symbols_loaded_next  = '0;
            symbols_used_next    = '0;
            nodes_used_next      = NodeW'(1);
            build_node_next      = '0;
            previous_bit_next    = 1'b1;
            build_finished_next  = 1'b0;
            walk_node_next       = '0;
            symbols_emitted_next = '0;
            halted_next          = 1'b0;
            root_left_next       = '0;
            root_right_next      = '0;
          end
        end
      end

      StBuildBit: begin
        if (bits_left == '0 || build_finished) begin
          state_next = StIdle;
        end else if (!bit_in) begin
          if (build_node == '0) begin
            // zero at the root ends the build
            build_finished_next = 1'b1;
          end else begin
            build_re   = 1'b1;
            state_next = StBuildClimb;
          end
        end else begin
          // descend into a fresh node if the node memory has room
          if (nodes_used < NodeW'(NodeLimit)) begin
            left_we         = 1'b1;
            right_we        = 1'b1;
            parent_we       = 1'b1;
            sym_we          = 1'b1;
            left_waddr      = nodes_used;
            right_waddr     = nodes_used;
            sym_waddr       = nodes_used;
            nodes_used_next = nodes_used + NodeW'(1);
            build_node_next = nodes_used;
            if (build_node == '0) begin
              if (!previous_bit) begin
                root_right_next = nodes_used;
              end else begin
                root_left_next = nodes_used;
              end
            end else begin
              link_node_next  = build_node;
              link_child_next = nodes_used;
              link_right_next = !previous_bit;
              state_next      = StBuildLink;
            end
          end
          previous_bit_next = 1'b1;
          shift_next        = shift << 1;
          bits_left_next    = bits_left - BitW'(1);
        end
      end

      StBuildLink: begin
        // hook the new node under its parent
        if (link_right) begin
          right_we    = 1'b1;
          right_waddr = link_node;
          right_wdata = link_child;
        end else begin
          left_we     = 1'b1;
          left_waddr  = link_node;
          left_wdata  = link_child;
        end
        state_next = StBuildBit;
      end

      StBuildClimb: begin
        // a zero right after a one turns the node into a leaf
        if (previous_bit) begin
          sym_we   = 1'b1;
          left_we  = 1'b1;
          right_we = 1'b1;
          if (symbols_used < LoadW'(MaxSymbols)) begin
            sym_wdata         = slist_q;
            symbols_used_next = symbols_used + LoadW'(1);
          end
        end
        build_node_next   = parent_q;
        previous_bit_next = 1'b0;
        shift_next        = shift << 1;
        bits_left_next    = bits_left - BitW'(1);
        state_next        = StBuildBit;
      end

      StDecode: begin
        if (chk && q_leaf) begin
          // reached a leaf: emit and restart at the root
          if (can_push) begin
            ev_result            = 1'b1;
            new_res.symbol       = sym_q;
            new_res.done         = (emitted_inc == output_length);
            symbols_emitted_next = emitted_inc;
            walk_node_next       = '0;
            chk_next             = 1'b0;
          end
        end else if (bits_left == '0 || halted || symbols_emitted >= output_length) begin
          // byte finished, decoder halted or length reached: release the held result marked as last
          if (can_push) begin
            ev_flush   = 1'b1;
            chk_next   = 1'b0;
            state_next = StIdle;
          end
        end else if (child == '0) begin
          // missing branch
          if (can_push) begin
            ev_result     = 1'b1;
            new_res.error = 1'b1;
            halted_next   = 1'b1;
            chk_next      = 1'b0;
          end
        end else begin
          node_re        = 1'b1;
          node_raddr     = child;
          walk_node_next = child;
          chk_next       = 1'b1;
          shift_next     = shift << 1;
          bits_left_next = bits_left - BitW'(1);
        end
      end

      default: state_next = StIdle;
    endcase

    // one result is held back until it is known whether it is the last
    if (ev_result) begin
      if (hold_valid) begin
        res_push      = 1'b1;
        res_data      = hold;
        res_data.last = 1'b0;
      end
      hold_next       = new_res;
      hold_valid_next = 1'b1;
    end else if (ev_flush) begin
      res_push        = hold_valid;
      res_data        = hold;
      res_data.last   = 1'b1;
      hold_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= StIdle;
      bits_left       <= '0;
      symbols_loaded  <= '0;
      symbols_used    <= '0;
      nodes_used      <= NodeW'(1);
      build_node      <= '0;
      previous_bit    <= 1'b1;
      build_finished  <= 1'b0;
      walk_node       <= '0;
      symbols_emitted <= '0;
      halted          <= 1'b0;
      root_left       <= '0;
      root_right      <= '0;
      chk             <= 1'b0;
      hold_valid      <= 1'b0;
    end else begin
      state           <= state_next;
      bits_left       <= bits_left_next;
      symbols_loaded  <= symbols_loaded_next;
      symbols_used    <= symbols_used_next;
      nodes_used      <= nodes_used_next;
      build_node      <= build_node_next;
      previous_bit    <= previous_bit_next;
      build_finished  <= build_finished_next;
      walk_node       <= walk_node_next;
      symbols_emitted <= symbols_emitted_next;
      halted          <= halted_next;
      root_left       <= root_left_next;
      root_right      <= root_right_next;
      chk             <= chk_next;
      hold_valid      <= hold_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    shift      <= shift_next;
    hold       <= hold_next;
    link_node  <= link_node_next;
    link_child <= link_child_next;
    link_right <= link_right_next;
  end

  // child link memories, read by the tree walk
  always_ff @(posedge clk) begin
    if (left_we) left_mem[left_waddr] <= left_wdata;
    if (node_re) left_q <= left_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (right_we) right_mem[right_waddr] <= right_wdata;
    if (node_re) right_q <= right_mem[node_raddr];
  end

  // leaf symbol memory
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
    if (node_re) sym_q <= sym_mem[node_raddr];
  end

  // parent memory, read when climbing
  always_ff @(posedge clk) begin
    if (parent_we) parent_mem[parent_waddr] <= parent_wdata;
    if (build_re) parent_q <= parent_mem[build_node];
  end

  // loaded symbol list
  always_ff @(posedge clk) begin
    if (slist_we) slist_mem[slist_waddr] <= cmd.data;
    if (build_re) slist_q <= slist_mem[symbols_used[ListW-1:0]];
  end

endmodule

// ----- rtl/huffman_tree_build_and_decode.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_build_and_decode
// Huffman decoder that builds its code tree from loaded symbols and topology
// bits, then walks it with coded bytes.
//
//   channel  | handshake        | fields
//   ---------+------------------+--------------------------------------
//   input    | push / full      | operation, data_byte
//   result   | pop / empty      | symbol, last, error, done_res
//   config   | cfg_write        | cfg_data (output_length)
//
// A topology byte steps through the bit state per bit plus the climb state per
// climb and the link state per non-root link; a coded byte steps through the
// decode state per bit and per decoded symbol, each bit waiting on one
// registered node memory read. Nodes are rewritten when allocated and the root
// links sit in flip-flops, so the node memories need no clearing pass.
// A full result queue stalls the engine; the input queue holds two items.
// ----------------------------------------------------------------------------
module huffman_tree_build_and_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [htd_pkg::OpW-1:0]  operation,
  input  logic [htd_pkg::SymW-1:0] data_byte,
  output logic                     empty,
  input  logic                     pop,
  output logic [htd_pkg::SymW-1:0] symbol,
  output logic                     last,
  output logic                     error,
  output logic                     done_res,
  input  logic                     cfg_write,
  input  logic [htd_pkg::LenW-1:0] cfg_data
);
  import htd_pkg::*;

  logic [LenW-1:0] output_length;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_take;
  logic            res_push;
  res_t            res_data;
  logic            res_full;
  res_t            res_out;

  // output length register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (cfg_write) begin
      output_length <= cfg_data;
    end
  end

  // input queue and operation decode
  htd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .operation (operation),
    .data_byte (data_byte),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // build and walk engine
  htd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .output_length (output_length),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .res_push      (res_push),
    .res_data      (res_data),
    .res_full      (res_full)
  );

  // result queue
  htd_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign symbol   = res_out.symbol;
  assign last     = res_out.last;
  assign error    = res_out.error;
  assign done_res = res_out.done;

endmodule

// ----- rtl/htd_checker.sv -----
// ----------------------------------------------------------------------------
// htd_checker
// Port level checks of the result side, bound to the top level.
// ----------------------------------------------------------------------------
module htd_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     empty,
  input logic                     pop,
  input logic [htd_pkg::SymW-1:0] symbol,
  input logic                     last,
  input logic                     error,
  input logic                     done_res
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result is not withdrawn
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished");

  // an error result carries a zero symbol, closes its byte and is not final
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (symbol == '0 && last && !done_res))
    else $error("malformed error result");

  // the final symbol closes the transaction of its coded byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> last)
    else $error("final symbol not marked last");

  // a stalled result keeps its payload
  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(symbol) && $stable(last) && $stable(error)))
    else $error("stalled result changed");

endmodule

bind huffman_tree_build_and_decode htd_checker u_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the huffman tree build and decode block. Symbols,
// tree topology and coded bytes go in through the push/full queue. A
// bit-accurate tree model predicts every decoded symbol, and each popped
// transaction is compared field by field. A short directed table comes first,
// then random tree sessions with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import htd_pkg::*;

  localparam int HoldCycles = 500;
  localparam int TailCycles = 64;
  localparam int StallLimit = 5000;
  localparam int ItemGoal   = 400;

  // how a directed row is checked
  typedef enum logic [1:0] {RowModel, RowQuiet, RowSingle, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [OpW-1:0]  op;
    logic [SymW-1:0] data;
    logic [LenW-1:0] len;
    res_t            want;
  } step_row_t;

  localparam res_t NoRes  = '0;
  localparam res_t ErrRes = '{symbol: '0, last: 1'b1, error: 1'b1, done: 1'b0};

  // directed table: three-leaf tree 0 -> 00, 10 -> ff, 11 -> a5, then a chain
  localparam step_row_t DirectedSteps [23] = '{
    '{RowWrite,  OpLoad,   8'h00, 24'd0,      NoRes},
    '{RowQuiet,  OpDecode, 8'hFF, 24'd0,      NoRes},   // length zero owes nothing
    '{RowWrite,  OpLoad,   8'h00, 24'hFFFFFF, NoRes},
    '{RowSingle, OpDecode, 8'h00, 24'd0,      ErrRes},  // empty tree, no branch at root
    '{RowQuiet,  OpDecode, 8'h55, 24'd0,      NoRes},   // decoder halted
    '{RowModel,  OpClear,  8'hFF, 24'd0,      NoRes},
    '{RowModel,  OpLoad,   8'h00, 24'd0,      NoRes},
    '{RowModel,  OpLoad,   8'hFF, 24'd0,      NoRes},
    '{RowModel,  OpLoad,   8'hA5, 24'd0,      NoRes},
    '{RowModel,  OpTopo,   8'hB4, 24'd0,      NoRes},
    '{RowModel,  OpTopo,   8'h7F, 24'd0,      NoRes},   // zero at root ends the build
    '{RowModel,  OpTopo,   8'hFF, 24'd0,      NoRes},   // ignored once built
    '{RowModel,  OpDecode, 8'hB6, 24'd0,      NoRes},
    '{RowModel,  OpDecode, 8'h81, 24'd0,      NoRes},   // walk left mid-tree
    '{RowModel,  OpDecode, 8'h40, 24'd0,      NoRes},
    '{RowWrite,  OpLoad,   8'h00, 24'd20,     NoRes},
    '{RowModel,  OpDecode, 8'h00, 24'd0,      NoRes},   // reaches the length
    '{RowQuiet,  OpDecode, 8'hFF, 24'd0,      NoRes},
    '{RowWrite,  OpLoad,   8'h00, 24'hFFFFFF, NoRes},
    '{RowModel,  OpClear,  8'h00, 24'd0,      NoRes},
    '{RowModel,  OpTopo,   8'hFF, 24'd0,      NoRes},   // chain of unlabelled nodes
    '{RowModel,  OpDecode, 8'h00, 24'd0,      NoRes},   // decode while still building
    '{RowSingle, OpDecode, 8'h80, 24'd0,      ErrRes}
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            full;
  logic [OpW-1:0]  operation = OpLoad;
  logic [SymW-1:0] data_byte = '0;
  logic            empty;
  logic            pop = 1'b0;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            error;
  logic            done_res;
  logic            cfg_write = 1'b0;
  logic [LenW-1:0] cfg_data = '0;

  // tree model state
  logic [NodeW-1:0] left_of  [NodeDepth];
  logic [NodeW-1:0] right_of [NodeDepth];
  logic [NodeW-1:0] up_of    [NodeDepth];
  logic [SymW-1:0]  byte_at  [NodeDepth];
  logic [SymW-1:0]  listed   [MaxSymbols];
  int unsigned      loaded_cnt, label_cnt, node_cnt;
  logic [NodeW-1:0] build_at, walk_at;
  bit               prev_bit, build_done, walk_halted;
  logic [LenW-1:0]  emitted_cnt, length_reg;

  res_t owed_results [$];
  bit   shape_bits [$];

  int  fail_count, items_live, items_sent, symbols_seen, errors_seen, sessions, idle_cycles;
  bit  send_calm, take_calm, hold_ask;

  huffman_tree_build_and_decode DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .data_byte (data_byte),
    .empty     (empty),
    .pop       (pop),
    .symbol    (symbol),
    .last      (last),
    .error     (error),
    .done_res  (done_res),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // back to an empty tree, length is kept
  function automatic void clear_tree();
    for (int n = 0; n < NodeDepth; n++) begin
      left_of[n]  = '0;
      right_of[n] = '0;
      up_of[n]    = '0;
      byte_at[n]  = '0;
    end
    for (int n = 0; n < MaxSymbols; n++) listed[n] = '0;
    loaded_cnt  = 0;
    label_cnt   = 0;
    node_cnt    = 1;
    build_at    = '0;
    prev_bit    = 1'b1;
    build_done  = 1'b0;
    walk_at     = '0;
    emitted_cnt = '0;
    walk_halted = 1'b0;
  endfunction

  // one topology bit: 1 descends into a new node, 0 climbs
  function automatic void grow_bit(bit b);
    logic [NodeW-1:0] at, fresh;
    at = build_at;
    if (!b) begin
      if (at == '0) begin
        build_done = 1'b1;
        return;
      end
      // a climb right after a descent labels a leaf
      if (prev_bit) begin
        if (label_cnt < MaxSymbols) begin
          byte_at[at] = listed[label_cnt];
          label_cnt++;
        end else begin
          byte_at[at] = '0;
        end
        left_of[at]  = '0;
        right_of[at] = '0;
      end
      build_at = up_of[at];
    end else if (node_cnt < NodeLimit) begin
      fresh = NodeW'(node_cnt);
      node_cnt++;
      left_of[fresh]  = '0;
      right_of[fresh] = '0;
      up_of[fresh]    = at;
      byte_at[fresh]  = '0;
      if (prev_bit) left_of[at] = fresh;
      else right_of[at] = fresh;
      build_at = fresh;
    end
    prev_bit = b;
  endfunction

  // predict one accepted transaction, returns how many results it owes
  function automatic int tree_step(input logic [OpW-1:0] op, input logic [SymW-1:0] val);
    res_t             got;
    logic [NodeW-1:0] nxt;
    int               made;
    made = 0;
    case (op)
      OpLoad: begin
        if (loaded_cnt < MaxSymbols) begin
          listed[loaded_cnt] = val;
          loaded_cnt++;
          items_live++;
        end
      end
      OpTopo: begin
        if (!build_done) items_live++;
        for (int i = ByteBits - 1; i >= 0 && !build_done; i--) grow_bit(val[i]);
      end
      OpClear: begin
        clear_tree();
        items_live++;
      end
      OpDecode: begin
        for (int i = ByteBits - 1; i >= 0; i--) begin
          if (walk_halted || emitted_cnt >= length_reg) break;
          nxt = val[i] ? right_of[walk_at] : left_of[walk_at];
          got = '0;
          // missing branch halts the decoder
          if (nxt == '0) begin
            got.error = 1'b1;
            owed_results.push_back(got);
            made++;
            walk_halted = 1'b1;
            break;
          end
          walk_at = nxt;
          if (left_of[nxt] == '0 && right_of[nxt] == '0) begin
            emitted_cnt++;
            got.symbol = byte_at[nxt];
            got.done   = (emitted_cnt == length_reg);
            owed_results.push_back(got);
            made++;
            walk_at = '0;
          end
        end
        if (made > 0) begin
          got = owed_results.pop_back();
          got.last = 1'b1;
          owed_results.push_back(got);
          items_live++;
        end
      end
    endcase
    return made;
  endfunction

  // random code tree in preorder: internal node 1 <left> 1 <right> 0, leaf 0
  function automatic void shape_subtree(int leaves, bit lean);
    int k;
    if (leaves <= 1) begin
      shape_bits.push_back(1'b0);
      return;
    end
    k = $urandom_range(1, leaves - 1);
    shape_bits.push_back(1'b1);
    shape_subtree(k, lean);
    // lean trees drop some right branches
    if (!(lean && $urandom_range(0, 3) == 0)) begin
      shape_bits.push_back(1'b1);
      shape_subtree(leaves - k, lean);
    end
    shape_bits.push_back(1'b0);
  endfunction

  // offer one transaction after a random gap and wait for acceptance
  task automatic send_item(input logic [OpW-1:0] op, input logic [SymW-1:0] val,
                           output int made);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    operation <= op;
    data_byte <= val;
    do @(posedge clk); while (full !== 1'b0);
    items_sent++;
    made = tree_step(op, val);
  endtask

  // a topology byte can label up to four leaves, keep the list ahead of it
  task automatic top_up();
    int made;
    while (loaded_cnt < MaxSymbols && loaded_cnt < label_cnt + 4)
      send_item(OpLoad, 8'($urandom), made);
  endtask

  // wait until nothing is owed and the engine has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_length(input logic [LenW-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write  <= 1'b0;
    length_reg = v;
  endtask

  // result side: random pops, one long hold on request
  initial begin : result_side
    int   pause;
    res_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        pause = HoldCycles;
      end else begin
        pause = take_calm ? 0 : $urandom_range(0, 15);
      end
      if (pause > 0) begin
        pop <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (owed_results.size() == 0) begin
        $error("unexpected result transaction: symbol %02h error %0b", symbol, error);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (want.error) errors_seen++;
        else symbols_seen++;
        if (symbol !== want.symbol) begin
          $error("symbol: expected %02h, got %02h", want.symbol, symbol);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fail_count++;
        end
        if (error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, error);
          fail_count++;
        end
        if (done_res !== want.done) begin
          $error("done_res: expected %0b, got %0b", want.done, done_res);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && full === 1'b0) || (pop && empty === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    step_row_t       row;
    int              made, leaves, bursts;
    bit              lean, big;
    logic [SymW-1:0] topo_byte;
    logic [LenW-1:0] len;

    length_reg = '0;
    clear_tree();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (DirectedSteps[r]) begin
      row = DirectedSteps[r];
      if (row.kind == RowWrite) begin
        write_length(row.len);
      end else begin
        send_item(row.op, row.data, made);
        if (row.kind != RowModel) begin
          repeat (made) void'(owed_results.pop_back());
          if (row.kind == RowSingle) owed_results.push_back(row.want);
        end
      end
    end

    // random tree sessions
    while (items_sent < ItemGoal || sessions < 3) begin
      sessions++;
      big = (sessions == 3);
      case ($urandom_range(0, 5))
        0:       len = 24'hFFFFFF;
        1:       len = '0;
        2:       len = LenW'($urandom_range(1, 40));
        default: len = LenW'($urandom_range(41, 24'hFFFFFF));
      endcase
      if (sessions == 2) len = 24'hFFFFFF;
      write_length(len);
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      // the hold session needs a complete tree so that every coded byte decodes
      lean      = (sessions != 2) && ($urandom_range(0, 4) == 0);
      leaves    = big ? 262 : $urandom_range((sessions == 2) ? 2 : 1, 24);

      // well-formed session: clear, symbols, topology, coded bytes
      send_item(OpClear, 8'($urandom), made);
      repeat (big ? 260 : leaves) send_item(OpLoad, 8'($urandom), made);
      shape_subtree(leaves, lean);
      while (shape_bits.size() > 0) begin
        for (int b = ByteBits - 1; b >= 0; b--)
          topo_byte[b] = (shape_bits.size() > 0) ? shape_bits.pop_front()
                                                  : 1'($urandom_range(0, 1));
        top_up();
        if (sessions != 2 && $urandom_range(0, 9) == 0)
          send_item(OpDecode, 8'($urandom), made);
        send_item(OpTopo, topo_byte, made);
      end

      // long receiver hold while coded bytes keep coming
      if (sessions == 2) begin
        hold_ask  = 1'b1;
        send_calm = 1'b1;
      end
      bursts = (sessions == 2) ? 60 : $urandom_range(10, 30);
      repeat (bursts) begin
        case ((sessions == 2) ? 23 : $urandom_range(0, 23))
          0: send_item(OpClear, 8'($urandom), made);
          1, 2: send_item(OpLoad, 8'($urandom), made);
          3, 4: begin
            top_up();
            send_item(OpTopo, 8'($urandom), made);
          end
          default: send_item(OpDecode, 8'($urandom), made);
        endcase
      end
    end

    settle();
    $display("covered %0d input transactions (%0d with an effect) over %0d tree sessions",
             items_sent, items_live, sessions);
    $display("checked %0d decoded symbols and %0d error results",
             symbols_seen, errors_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
